// File: hw/rtl/dtsh_pkg.sv
`timescale 1ns / 1ps

package dtsh_pkg;

  // Default build of the shaper.
  localparam int NUM_CHANNELS_DEFAULT = 2;
  localparam int SAMPLE_WIDTH_DEFAULT = 24;

  // Fixed field widths.
  localparam int COEF_W     = 16;
  localparam int AMOUNT_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int RATIO_W    = 16;
  localparam int GAIN_W     = 16;

  // The shared multiplier takes a coefficient, gain difference or blend gain on its B side.
  localparam int MUL_B_W = COEF_W + 2;

  // The divider retires two quotient bits per cycle.
  localparam int DIV_STEPS = RATIO_W / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Rounding terms and the Q2.14 output shift.
  localparam int BLEND_ROUND = 32768;
  localparam int OUT_ROUND   = 8192;
  localparam int OUT_SHIFT   = 14;

  // Gain limits in Q2.14: unity, half and double.
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;
  localparam logic [GAIN_W-1:0] GAIN_MIN   = 16'd8192;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;

  // Coefficient values after reset.
  localparam logic [COEF_W-1:0] FAST_ATTACK_RST  = 16'd65277;
  localparam logic [COEF_W-1:0] FAST_RELEASE_RST = 16'd65508;
  localparam logic [COEF_W-1:0] SLOW_ATTACK_RST  = 16'd65508;
  localparam logic [COEF_W-1:0] SLOW_RELEASE_RST = 16'd65533;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST_ATTACK  = 3'd0,
    REG_FAST_RELEASE = 3'd1,
    REG_SLOW_ATTACK  = 3'd2,
    REG_SLOW_RELEASE = 3'd3,
    REG_ATTACK_AMT   = 3'd4,
    REG_DECAY_AMT    = 3'd5
  } cfg_reg_e;

  // Settings handed from the register bank to the sequencer.
  typedef struct packed {
    logic [COEF_W-1:0] fast_attack;
    logic [COEF_W-1:0] fast_release;
    logic [COEF_W-1:0] slow_attack;
    logic [COEF_W-1:0] slow_release;
    logic [GAIN_W-1:0] gain_att;
    logic [GAIN_W-1:0] gain_dec;
    logic              bypass;
  } dtsh_cfg_t;

  // Amount to gain table, one entry per 8-bit register code.
  typedef logic [GAIN_W-1:0] gain_lut_t [256];

  function automatic gain_lut_t build_gain_lut();
    gain_lut_t lut;
    int        a;
    for (int i = 0; i < 256; i++) begin
      a = (i >= 128) ? i - 256 : i;
      if (a < -127) begin
        a = -127;
      end
      if (a >= 0) begin
        lut[i] = GAIN_W'(16384 + (a * 16384 + 63) / 127);
      end else begin
        lut[i] = GAIN_W'(16384 - ((-a) * 8192 + 63) / 127);
      end
    end
    return lut;
  endfunction

  localparam gain_lut_t GAIN_LUT = build_gain_lut();

endpackage

// File: hw/rtl/dtsh_if.sv
`timescale 1ns / 1ps

// Sample input channel.
interface dtsh_in_if #(
  parameter int SAMPLE_WIDTH = dtsh_pkg::SAMPLE_WIDTH_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic                           channel_sel;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output channel_sel, output sample_in, input ready);
  modport sink (input valid, input channel_sel, input sample_in, output ready);
endinterface

// Shaped sample output channel.
interface dtsh_out_if #(
  parameter int SAMPLE_WIDTH = dtsh_pkg::SAMPLE_WIDTH_DEFAULT
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

// Configuration write channel.
interface dtsh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dtsh_pkg::CFG_IDX_W-1:0]  index;
  logic [dtsh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/dtsh_cfg.sv
`timescale 1ns / 1ps

module dtsh_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  dtsh_cfg_if.sink            cfg_i,
  output dtsh_pkg::dtsh_cfg_t cfg_o
);
  import dtsh_pkg::*;

  logic [COEF_W-1:0]   fast_attack_q;
  logic [COEF_W-1:0]   fast_release_q;
  logic [COEF_W-1:0]   slow_attack_q;
  logic [COEF_W-1:0]   slow_release_q;
  logic [AMOUNT_W-1:0] attack_amt_q;
  logic [AMOUNT_W-1:0] decay_amt_q;
  logic [GAIN_W-1:0]   gain_att_q;
  logic [GAIN_W-1:0]   gain_dec_q;

  // Writes are always taken.
  assign cfg_i.ready = 1'b1;

  // Register bank; the gains are looked up once when an amount is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_attack_q  <= FAST_ATTACK_RST;
      fast_release_q <= FAST_RELEASE_RST;
      slow_attack_q  <= SLOW_ATTACK_RST;
      slow_release_q <= SLOW_RELEASE_RST;
      attack_amt_q   <= '0;
      decay_amt_q    <= '0;
      gain_att_q     <= GAIN_UNITY;
      gain_dec_q     <= GAIN_UNITY;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FAST_ATTACK:  fast_attack_q  <= cfg_i.data;
        REG_FAST_RELEASE: fast_release_q <= cfg_i.data;
        REG_SLOW_ATTACK:  slow_attack_q  <= cfg_i.data;
        REG_SLOW_RELEASE: slow_release_q <= cfg_i.data;
        REG_ATTACK_AMT: begin
          attack_amt_q <= cfg_i.data[AMOUNT_W-1:0];
          gain_att_q   <= GAIN_LUT[cfg_i.data[AMOUNT_W-1:0]];
        end
        REG_DECAY_AMT: begin
          decay_amt_q <= cfg_i.data[AMOUNT_W-1:0];
          gain_dec_q  <= GAIN_LUT[cfg_i.data[AMOUNT_W-1:0]];
        end
        default: begin
        end
      endcase
    end
  end

  // Settings seen by the sequencer.
  always_comb begin
    cfg_o.fast_attack  = fast_attack_q;
    cfg_o.fast_release = fast_release_q;
    cfg_o.slow_attack  = slow_attack_q;
    cfg_o.slow_release = slow_release_q;
    cfg_o.gain_att     = gain_att_q;
    cfg_o.gain_dec     = gain_dec_q;
    cfg_o.bypass       = (attack_amt_q == '0) && (decay_amt_q == '0);
  end

endmodule

// File: hw/rtl/dtsh_mul.sv
`timescale 1ns / 1ps

module dtsh_mul #(
  parameter int A_W = dtsh_pkg::SAMPLE_WIDTH_DEFAULT + 1,
  parameter int B_W = dtsh_pkg::MUL_B_W
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [A_W-1:0]   a_i,
  input  logic signed [B_W-1:0]   b_i,
  output logic signed [A_W+B_W-1:0] prod_o
);
  logic signed [A_W+B_W-1:0] prod_q;

  // Signed product, registered; it holds while the unit is not enabled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: hw/rtl/dtsh_div.sv
`timescale 1ns / 1ps

module dtsh_div #(
  parameter int SAMPLE_WIDTH = dtsh_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [SAMPLE_WIDTH:0]          num_i,
  input  logic [SAMPLE_WIDTH:0]          den_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [dtsh_pkg::RATIO_W-1:0]   quot_o
);
  import dtsh_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic [SW:0]          rem_q;
  logic [SW:0]          den_q;
  logic [RATIO_W-1:0]   quot_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [SW+1:0] r1_sh;
  logic [SW+1:0] r1;
  logic [SW+1:0] r2_sh;
  logic [SW+1:0] r2;
  logic          ge1;
  logic          ge2;

  // Two restoring steps per cycle; the remainder stays below the divisor if the numerator starts below it.
  always_comb begin
    r1_sh = {rem_q, 1'b0};
    ge1   = r1_sh >= {1'b0, den_q};
    r1    = ge1 ? r1_sh - {1'b0, den_q} : r1_sh;
    r2_sh = {r1[SW:0], 1'b0};
    ge2   = r2_sh >= {1'b0, den_q};
    r2    = ge2 ? r2_sh - {1'b0, den_q} : r2_sh;
  end

  // Step counter and quotient shift register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= num_i;
        den_q  <= den_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= r2[SW:0];
        quot_q <= {quot_q[RATIO_W-3:0], ge1, ge2};
        cnt_q  <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: hw/rtl/dual_envelope_transient_shaper_top.sv
`timescale 1ns / 1ps

// Dual envelope transient shaper.
// Words enter on in_i (channel_sel, sample_in) and leave on out_o (sample_out),
// both valid/ready channels; cfg_i writes the six settings registers by index
// and is always ready. Settings should only change while no word is in flight.
// One word is processed at a time: in_i is ready only while the sequencer is idle.
// A shaped word steps through the envelope updates, division, blend, output product
// and rounding before it reaches out_o. The shared multiplier is used four times
// (two envelope updates, the gain blend and the output product) and the ratio
// divider retires two quotient bits a cycle.
// A bypassed word (both amounts zero, or a channel that is not built) goes straight
// to the output step after acceptance and leaves the envelopes untouched.
// A finished word sits in the output register until taken; the next word is
// accepted meanwhile and waits in its last step if out_o is still stalled.
// Reset clears the envelopes to zero and restores the register defaults.
module dual_envelope_transient_shaper_top #(
  parameter int NUM_CHANNELS = dtsh_pkg::NUM_CHANNELS_DEFAULT,
  parameter int SAMPLE_WIDTH = dtsh_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtsh_cfg_if.sink   cfg_i,
  dtsh_in_if.sink    in_i,
  dtsh_out_if.source out_o
);
  import dtsh_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MA_W = SW + 1;
  localparam int MB_W = MUL_B_W;
  localparam int P_W  = MA_W + MB_W;
  localparam longint unsigned EpsVal = ((64'd1 << (SW - 1)) + 64'd5000) / 64'd10000;
  localparam logic [SW:0] EPS = (SW + 1)'(EpsVal);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FAST,
    S_SLOW,
    S_SLOW_WB,
    S_DIV_START,
    S_DIV,
    S_BLEND,
    S_BLEND_WB,
    S_OUT_MUL,
    S_ROUND,
    S_OUT
  } state_e;

  state_e                 state_q;
  logic                   ch_q;
  logic signed [SW-1:0]   x_q;
  logic [SW-1:0]          rect_q;
  logic [SW-1:0]          fast_env_q [NUM_CHANNELS];
  logic [SW-1:0]          slow_env_q [NUM_CHANNELS];
  logic [SW-1:0]          fe_q;
  logic [SW-1:0]          se_q;
  logic signed [GAIN_W:0] gdiff_q;
  logic [GAIN_W-1:0]      blend_q;
  logic [SW-1:0]          res_q;
  logic [SW-1:0]          out_data_q;
  logic                   out_valid_q;

  dtsh_cfg_t cfg;

  logic [CH_W-1:0]        ch_idx;
  logic [SW-1:0]          fast_cur;
  logic [SW-1:0]          slow_cur;
  logic [COEF_W-1:0]      fast_coef;
  logic [COEF_W-1:0]      slow_coef;
  logic signed [SW:0]     fast_diff;
  logic signed [SW:0]     slow_diff;
  logic signed [P_W-1:0]  env_acc;
  logic [SW-1:0]          env_new;
  logic signed [P_W-1:0]  blend_sum;
  logic [GAIN_W-1:0]      blend_new;
  logic signed [P_W-1:0]  p_rnd;
  logic [SW+4:0]          y_full;
  logic                   y_fits;
  logic [SW-1:0]          y_sat;

  logic                   mul_en;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  prod;

  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [SW:0]            div_num;
  logic [SW:0]            div_den;
  logic [RATIO_W-1:0]     ratio;

  // Settings registers.
  dtsh_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Shared multiplier.
  dtsh_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Ratio divider.
  dtsh_div #(
    .SAMPLE_WIDTH (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (ratio)
  );

  // Envelope follower operands: c * (env - rect) is added to rect scaled by 2^16.
  always_comb begin
    ch_idx    = CH_W'(ch_q);
    fast_cur  = fast_env_q[ch_idx];
    slow_cur  = slow_env_q[ch_idx];
    fast_coef = (rect_q > fast_cur) ? cfg.fast_attack : cfg.fast_release;
    slow_coef = (rect_q > slow_cur) ? cfg.slow_attack : cfg.slow_release;
    fast_diff = $signed({1'b0, fast_cur}) - $signed({1'b0, rect_q});
    slow_diff = $signed({1'b0, slow_cur}) - $signed({1'b0, rect_q});
    env_acc   = $signed({3'b000, rect_q, {COEF_W{1'b0}}}) + prod;
    env_new   = env_acc[SW+COEF_W-1:COEF_W];
  end

  // Gain blend: decay gain plus ratio times the gain difference, rounded.
  always_comb begin
    blend_sum = $signed(P_W'({cfg.gain_dec, {RATIO_W{1'b0}}})) + prod
                + $signed(P_W'(BLEND_ROUND));
    blend_new = blend_sum[RATIO_W+GAIN_W-1:RATIO_W];
  end

  // Output rounding, half up, then saturation to the sample range.
  always_comb begin
    p_rnd  = prod + $signed(P_W'(OUT_ROUND));
    y_full = p_rnd[P_W-1:OUT_SHIFT];
    y_fits = (&y_full[SW+4:SW-1]) || !(|y_full[SW+4:SW-1]);
    if (y_fits) begin
      y_sat = y_full[SW-1:0];
    end else if (y_full[SW+4]) begin
      y_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  // Divider operands: transient level over fast envelope plus epsilon.
  always_comb begin
    div_num   = (fe_q > se_q) ? {1'b0, fe_q - se_q} : '0;
    div_den   = {1'b0, fe_q} + EPS;
    div_start = (state_q == S_DIV_START);
  end

  // Multiplier operand selection per step.
  always_comb begin
    mul_en = state_q inside {S_FAST, S_SLOW, S_BLEND, S_OUT_MUL};
    case (state_q)
      S_FAST: begin
        mul_a = fast_diff;
        mul_b = $signed({2'b00, fast_coef});
      end
      S_SLOW: begin
        mul_a = slow_diff;
        mul_b = $signed({2'b00, slow_coef});
      end
      S_BLEND: begin
        mul_a = $signed(MA_W'(ratio));
        mul_b = MB_W'(gdiff_q);
      end
      S_OUT_MUL: begin
        mul_a = MA_W'(x_q);
        mul_b = $signed({2'b00, blend_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // Sequencer with envelope state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= 1'b0;
      x_q         <= '0;
      rect_q      <= '0;
      fe_q        <= '0;
      se_q        <= '0;
      gdiff_q     <= '0;
      blend_q     <= '0;
      res_q       <= '0;
      out_data_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        fast_env_q[i] <= '0;
        slow_env_q[i] <= '0;
      end
    end else begin
      // The output register empties when taken, unless a new word refills it.
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            x_q    <= in_i.sample_in;
            ch_q   <= in_i.channel_sel;
            res_q  <= in_i.sample_in;
            rect_q <= in_i.sample_in[SW-1] ? SW'(~in_i.sample_in + 1'b1) : in_i.sample_in;
            if (cfg.bypass || (in_i.channel_sel && (NUM_CHANNELS < 2))) begin
              state_q <= S_OUT;
            end else begin
              state_q <= S_FAST;
            end
          end
        end
        S_FAST: begin
          state_q <= S_SLOW;
        end
        S_SLOW: begin
          fast_env_q[ch_idx] <= env_new;
          fe_q               <= env_new;
          state_q            <= S_SLOW_WB;
        end
        S_SLOW_WB: begin
          slow_env_q[ch_idx] <= env_new;
          se_q               <= env_new;
          state_q            <= S_DIV_START;
        end
        S_DIV_START: begin
          gdiff_q <= $signed({1'b0, cfg.gain_att}) - $signed({1'b0, cfg.gain_dec});
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_BLEND;
          end
        end
        S_BLEND: begin
          state_q <= S_BLEND_WB;
        end
        S_BLEND_WB: begin
          blend_q <= blend_new;
          state_q <= S_OUT_MUL;
        end
        S_OUT_MUL: begin
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          res_q   <= y_sat;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_data_q  <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The blended gain always lies between half and double.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT_MUL) |-> (blend_q >= GAIN_MIN && blend_q <= GAIN_MAX))
    else $error("blend gain out of range");

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  // A finished word is held back while the output register is still occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_o.ready) |=> (state_q == S_OUT))
    else $error("output register overwritten");

  // The divider is never left running when the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_busy)
    else $error("divider busy while idle");

endmodule
